// ===== hw/rtl/sv39ptw_pkg.sv =====
// Shared constants and types for the Sv39 page table walker.
package sv39ptw_pkg;

  localparam int unsigned TABLE_PAGES      = 8;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned SLOT_W           = $clog2(TABLE_PAGES);
  localparam int unsigned ADDR_W           = SLOT_W + IDX_W;
  localparam int unsigned DEPTH            = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned VA_W             = 39;
  localparam int unsigned PA_W             = 56;

  typedef logic [PPN_W-1:0] ppn_t;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_INVALID      = 2'd1;
  localparam logic [1:0] ST_LAST_POINTER = 2'd2;
  localparam logic [1:0] ST_OUTSIDE      = 2'd3;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROOT = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } page_chk_t;

endpackage

// ===== hw/rtl/sv39ptw_page_chk.sv =====
// Shared page range unit: maps a table PPN to a store slot or flags it outside.
module sv39ptw_page_chk (
  input  sv39ptw_pkg::ppn_t      ppn_i,
  input  sv39ptw_pkg::ppn_t      base_i,
  output sv39ptw_pkg::page_chk_t chk_o
);
  import sv39ptw_pkg::*;

  logic [PPN_W:0] off;

  // borrow out of the subtract means ppn is below the store base
  assign off        = {1'b0, ppn_i} - {1'b0, base_i};
  assign chk_o.ok   = !off[PPN_W] && (off[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
  assign chk_o.slot = off[SLOT_W-1:0];

endmodule

// ===== hw/rtl/sv39_page_table_walk.sv =====
// Top level of the Sv39 page table walker with its local page-table store.
//
// Input channel (in_valid_i / in_stall_o) carries one command word: a write of
// one 64-bit entry into store slot table_slot_i, entry entry_index_i, or a
// translation of virt_addr_i. Every word gives exactly one result word on the
// output channel (out_valid_o / out_stall_i): phys_addr_o, status_o and
// leaf_level_o. Writes return all zeros.
// A translation makes one registered store read per level, up to three dependent
// reads; each table PPN is range checked by the one shared page range unit and
// each read entry is decoded, then the result moves from the result registers
// into the output register. A new word is taken once the previous result has
// moved into the output register, so no word is taken while one is in flight.
// After reset the store is cleared one entry a cycle, all TABLE_PAGES * 512
// entries; in_stall_o stays high meanwhile. Configuration writes
// (root and store base PPN) are taken at any time and should be made while idle.
// When the receiver stalls, the result holds in the output register; a
// finished result behind it waits and the input stalls.
module sv39_page_table_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  sv39ptw_pkg::ppn_t         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [2:0]                table_slot_i,
  input  logic [8:0]                entry_index_i,
  input  logic [63:0]               entry_data_i,
  input  logic [sv39ptw_pkg::VA_W-1:0] virt_addr_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sv39ptw_pkg::PA_W-1:0] phys_addr_o,
  output logic [1:0]                status_o,
  output logic [1:0]                leaf_level_o
);
  import sv39ptw_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  ppn_t             root_q, base_q;
  logic [VA_W-1:0]  va_q, va_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [PA_W-1:0]  res_pa_q, res_pa_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [1:0]       res_lvl_q, res_lvl_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;

  logic [63:0]       mem [DEPTH];
  logic [63:0]       rd_q;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [63:0]       wr_data;

  ppn_t      chk_ppn, pte_ppn;
  page_chk_t chk;
  logic      in_acc, slot_ok;
  logic [IDX_W-1:0] vpn_next;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign pte_ppn    = rd_q[53:10];
  assign chk_ppn    = (state_q == S_EVAL) ? pte_ppn : root_q;
  assign slot_ok    = ({29'd0, table_slot_i} < 32'(TABLE_PAGES));
  assign vpn_next   = (lvl_q == 2'd2) ? va_q[29:21] : va_q[20:12];

  sv39ptw_page_chk u_chk (
    .ppn_i  (chk_ppn),
    .base_i (base_q),
    .chk_o  (chk)
  );

  // store write port: clearing pass or write command
  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      mem_we  = in_acc && (cmd_i == CMD_WRITE) && slot_ok;
      wr_addr = {SLOT_W'(table_slot_i), entry_index_i};
      wr_data = entry_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    va_d      = va_q;
    lvl_d     = lvl_q;
    res_pa_d  = res_pa_q;
    res_st_d  = res_st_q;
    res_lvl_d = res_lvl_q;
    rd_en     = 1'b0;
    rd_addr   = {chk.slot, vpn_next};
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_pa_d  = '0;
          res_st_d  = ST_OK;
          res_lvl_d = 2'd0;
          va_d      = virt_addr_i;
          state_d   = S_FIN;
          if (cmd_i == CMD_XLATE) begin
            // root lookup issued straight from the input word
            if (!chk.ok) begin
              res_st_d = ST_OUTSIDE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = {chk.slot, virt_addr_i[38:30]};
              lvl_d   = 2'd2;
              state_d = S_EVAL;
            end
          end
        end
      end
      S_EVAL: begin
        state_d = S_FIN;
        if (!rd_q[0]) begin
          res_st_d = ST_INVALID;
        end else if (rd_q[3:1] == 3'b000) begin
          // pointer to next table
          if (lvl_q == 2'd0) begin
            res_st_d = ST_LAST_POINTER;
          end else if (!chk.ok) begin
            res_st_d = ST_OUTSIDE;
          end else begin
            rd_en   = 1'b1;
            lvl_d   = lvl_q - 2'd1;
            state_d = S_EVAL;
          end
        end else begin
          res_lvl_d = lvl_q;
          unique case (lvl_q)
            2'd0:    res_pa_d = {pte_ppn, va_q[11:0]};
            2'd1:    res_pa_d = {pte_ppn[43:9], va_q[20:0]};
            default: res_pa_d = {pte_ppn[43:18], va_q[29:0]};
          endcase
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      root_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROOT: root_q <= cfg_data_i;
          CFG_BASE: base_q <= cfg_data_i;
          default:  root_q <= root_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q      <= va_d;
    lvl_q     <= lvl_d;
    res_pa_q  <= res_pa_d;
    res_st_q  <= res_st_d;
    res_lvl_q <= res_lvl_d;
    if (out_load) begin
      phys_addr_o  <= res_pa_q;
      status_o     <= res_st_q;
      leaf_level_o <= res_lvl_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the Sv39 page table walker with its local page store.
`timescale 1ns / 100ps

module tb;
  import sv39ptw_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;
  typedef enum logic [1:0] {EK_PTR, EK_LEAF, EK_INV, EK_FAR} ent_kind_e;

  typedef struct packed {
    logic             cmd;
    logic [2:0]       slot;
    logic [8:0]       idx;
    logic [63:0]      data;
    logic [VA_W-1:0]  va;
  } req_word_t;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic [1:0]      st;
    logic [1:0]      lvl;
  } walk_res_t;

  typedef struct {
    req_word_t w;
    bit        typed;
    walk_res_t res;
  } dir_row_t;

  typedef struct {
    ppn_t  base;
    ppn_t  root_off;
    bit    rnd_base;
    idle_e mode;
    int    items;
    int    hold;
  } phase_t;

  localparam int WDOG_LIMIT = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CFG_ROOT;
  ppn_t              cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              cmd_i = CMD_WRITE;
  logic [2:0]        table_slot_i = '0;
  logic [8:0]        entry_index_i = '0;
  logic [63:0]       entry_data_i = '0;
  logic [VA_W-1:0]   virt_addr_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PA_W-1:0]   phys_addr_o;
  logic [1:0]        status_o;
  logic [1:0]        leaf_level_o;

  sv39_page_table_walk dut (.*);

  // shadow of the block's page store and registers
  logic [63:0] pte_shadow [DEPTH];
  ppn_t        cfg_root;
  ppn_t        cfg_base;

  walk_res_t   walk_results_due [$];
  idle_e       idle_mode = IDLE_NONE;
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  int          hold_req = 0;
  int          hold_left = 0;

  dir_row_t    dir_tab [0:20];
  phase_t      phases [0:8];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] ptr_pte(input ppn_t ppn);
    return {10'd0, ppn, 10'h001};
  endfunction

  function automatic walk_res_t walk_predict(input logic [VA_W-1:0] va);
    walk_res_t   r;
    ppn_t        tbl;
    ppn_t        off;
    ppn_t        ppn;
    logic [63:0] pte;
    logic [8:0]  vpn;
    int          lvl;
    bit          done;
    r = '0;
    tbl = cfg_root;
    done = 1'b0;
    for (lvl = 2; lvl >= 0; lvl--) begin
      if (!done) begin
        vpn = va[12 + 9 * lvl +: 9];
        off = tbl - cfg_base;
        if (tbl < cfg_base || off >= ppn_t'(TABLE_PAGES)) begin
          r.st = ST_OUTSIDE;
          done = 1'b1;
        end else begin
          pte = pte_shadow[int'(off) * ENTRIES_PER_PAGE + int'(vpn)];
          ppn = pte[53:10];
          if (!pte[0]) begin
            r.st = ST_INVALID;
            done = 1'b1;
          end else if (pte[3:1] == 3'b000) begin
            // pointer: descend, unless there is no level left
            if (lvl == 0) begin
              r.st = ST_LAST_POINTER;
              done = 1'b1;
            end else begin
              tbl = ppn;
            end
          end else begin
            // superpage: low PPN fields give way to VA bits
            case (lvl)
              0: r.pa = {ppn, va[11:0]};
              1: r.pa = {ppn[43:9], va[20:0]};
              default: r.pa = {ppn[43:18], va[29:0]};
            endcase
            r.lvl = 2'(lvl);
            done = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 71;
      IDLE_BOTH: return $urandom_range(99) < 7;
      default: return 1'b0;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input req_word_t w, input bit typed, input walk_res_t typed_res);
    walk_res_t pred;
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= w.cmd;
    table_slot_i  <= w.slot;
    entry_index_i <= w.idx;
    entry_data_i  <= w.data;
    virt_addr_i   <= w.va;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pred = '0;
    if (w.cmd == CMD_WRITE) begin
      if (int'(w.slot) < TABLE_PAGES)
        pte_shadow[int'(w.slot) * ENTRIES_PER_PAGE + int'(w.idx)] = w.data;
    end else begin
      pred = walk_predict(w.va);
    end
    walk_results_due.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_t ph);
    ppn_t            base;
    ppn_t            root;
    ppn_t            tbl;
    ppn_t            off;
    ppn_t            nppn;
    logic [127:0]    rnd;
    logic [63:0]     pte;
    logic [VA_W-1:0] va;
    req_word_t       w;
    req_word_t       plan [$];
    ent_kind_e       kind;
    int              sent;
    int              k;
    int              lvl;
    bit              more;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    base = ph.rnd_base ? rnd[PPN_W-1:0] : ph.base;
    root = base + ph.root_off;

    // registers only change with the block empty
    in_valid_i <= 1'b0;
    while (walk_results_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROOT;
    cfg_data_i <= root;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_BASE;
    cfg_data_i <= base;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_root = root;
    cfg_base = base;
    idle_mode = ph.mode;
    hold_req = ph.hold;

    sent = 0;
    while (sent < ph.items) begin
      rnd = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(99) < 15) begin
        w = rnd[$bits(req_word_t)-1:0];
        send_word(w, 1'b0, '0);
        sent++;
      end else begin
        // lay out one walk with random entries, then translate along it
        plan.delete();
        va = rnd[VA_W-1:0];
        tbl = root;
        more = 1'b1;
        for (lvl = 2; lvl >= 0; lvl--) begin
          off = tbl - base;
          if (more && tbl >= base && off < ppn_t'(TABLE_PAGES)) begin
            k = $urandom_range(99);
            if (lvl > 0)
              kind = k < 70 ? EK_PTR : k < 85 ? EK_LEAF : k < 92 ? EK_INV : EK_FAR;
            else
              kind = k < 80 ? EK_LEAF : k < 90 ? EK_PTR : EK_INV;
            rnd = {$urandom, $urandom, $urandom, $urandom};
            pte = rnd[63:0];
            nppn = base + ppn_t'($urandom_range(TABLE_PAGES - 1));
            more = 1'b0;
            case (kind)
              EK_PTR: begin
                pte[53:10] = nppn;
                pte[3:0] = 4'b0001;
                tbl = nppn;
                more = 1'b1;
              end
              EK_LEAF: begin
                pte[0] = 1'b1;
                if (pte[3:1] == 3'b000) pte[3:1] = 3'($urandom_range(7, 1));
              end
              EK_INV: pte[0] = 1'b0;
              default: begin
                // wraps below base when base sits near the top
                pte[53:10] = base + ppn_t'(TABLE_PAGES + $urandom_range(999));
                pte[3:0] = 4'b0001;
              end
            endcase
            w.cmd = CMD_WRITE;
            w.slot = off[2:0];
            w.idx = va[12 + 9 * lvl +: 9];
            w.data = pte;
            w.va = rnd[127:89];
            plan.push_back(w);
          end else begin
            more = 1'b0;
          end
        end
        repeat ($urandom_range(3, 1)) begin
          rnd = {$urandom, $urandom, $urandom, $urandom};
          w = rnd[$bits(req_word_t)-1:0];
          w.cmd = CMD_XLATE;
          w.va = {va[VA_W-1:12], rnd[127:116]};
          plan.push_back(w);
        end
        foreach (plan[i]) send_word(plan[i], 1'b0, '0);
        sent += plan.size();
      end
    end
  endtask

  // result side stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_stall_i <= ($urandom_range(99) < 71);
        IDLE_BOTH: out_stall_i <= ($urandom_range(99) < 7);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    walk_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (walk_results_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word: phys_addr %h status %0d level %0d",
                 $time, phys_addr_o, status_o, leaf_level_o);
      end else begin
        want = walk_results_due.pop_front();
        if (want !== {phys_addr_o, status_o, leaf_level_o}) begin
          err_cnt++;
          $display("%0t: mismatch: exp phys_addr %h status %0d level %0d, got %h %0d %0d",
                   $time, want.pa, want.st, want.lvl, phys_addr_o, status_o, leaf_level_o);
        end
      end
    end
  end

  // includes the store clear after reset
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    foreach (pte_shadow[i]) pte_shadow[i] = '0;
    cfg_root = '0;
    cfg_base = '0;

    dir_tab = '{
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, 39'd0}, 1'b1, '{56'd0, ST_INVALID, 2'd0}},
      '{'{CMD_XLATE, 3'h7, 9'h1FF, '1, '1}, 1'b1, '{56'd0, ST_INVALID, 2'd0}},
      '{'{CMD_WRITE, 3'd0, 9'd0, ptr_pte(44'd1), '1}, 1'b1, '0},
      '{'{CMD_WRITE, 3'd1, 9'd0, ptr_pte(44'd2), 39'd0}, 1'b1, '0},
      '{'{CMD_WRITE, 3'd2, 9'd0, '1, 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, 39'h00_0000_0ABC}, 1'b1,
        '{56'hFF_FFFF_FFFF_FABC, ST_OK, 2'd0}},
      '{'{CMD_WRITE, 3'd0, 9'h1FF, {10'h2A5, 44'hABC_DEF0_1234, 10'h0C3}, 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'h1FF, 30'h2345_6789}}, 1'b0, '0},
      '{'{CMD_WRITE, 3'd0, 9'd1, ptr_pte(44'd3), 39'd0}, 1'b1, '0},
      // W set, R clear: still taken as a leaf
      '{'{CMD_WRITE, 3'd3, 9'd5, {10'h3FF, 44'hFFF_FFFF_FFFF, 10'h005}, 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'd1, 9'd5, 21'h1F_FFFF}}, 1'b0, '0},
      '{'{CMD_WRITE, 3'd3, 9'd6, ptr_pte(44'd4), 39'd0}, 1'b1, '0},
      '{'{CMD_WRITE, 3'd4, 9'd0, ptr_pte(44'd5), 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'd1, 9'd6, 9'd0, 12'h000}}, 1'b1,
        '{56'd0, ST_LAST_POINTER, 2'd0}},
      '{'{CMD_WRITE, 3'd3, 9'd7, ptr_pte(44'd9), 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'd1, 9'd7, 21'h0}}, 1'b1,
        '{56'd0, ST_OUTSIDE, 2'd0}},
      '{'{CMD_WRITE, 3'd0, 9'd2, 64'hFFFF_FFFF_FFFF_FFFE, 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'd2, 30'h3FFF_FFFF}}, 1'b1,
        '{56'd0, ST_INVALID, 2'd0}},
      '{'{CMD_WRITE, 3'd7, 9'h1FF, '1, 39'd0}, 1'b1, '0},
      '{'{CMD_WRITE, 3'd4, 9'd1, 64'h9, 39'd0}, 1'b1, '0},
      '{'{CMD_XLATE, 3'd0, 9'd0, 64'd0, {9'd1, 9'd6, 9'd1, 12'hFFF}}, 1'b0, '0}
    };

    phases = '{
      '{44'd0, 44'd0, 1'b0, IDLE_NONE, 230, 0},
      '{44'h123_4567_89A0, 44'd3, 1'b0, IDLE_SEND, 230, 0},
      '{44'hFFF_FFFF_FFF8, 44'd7, 1'b0, IDLE_NONE, 230, 400},
      '{44'hFFF_FFFF_FFFF, 44'd0, 1'b0, IDLE_RECV, 230, 0},
      '{44'd0, 44'd2, 1'b1, IDLE_BOTH, 230, 0},
      // root out of reach, above and below the store
      '{44'd0, 44'hFFF_FFFF_FFFF, 1'b0, IDLE_SEND, 50, 0},
      '{44'd0, 44'hFFF_FFFF_FFFF, 1'b1, IDLE_RECV, 50, 0},
      '{44'd0, 44'd5, 1'b1, IDLE_BOTH, 230, 0},
      '{44'd1, 44'd6, 1'b0, IDLE_RECV, 230, 0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
    foreach (phases[p]) run_phase(phases[p]);

    in_valid_i <= 1'b0;
    while (walk_results_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sv39ptw_pkg.sv
hw/rtl/sv39ptw_page_chk.sv
hw/rtl/sv39_page_table_walk.sv
sim/tb.sv
